@@ rtl/dkm_pkg.sv @@
// ----------------------------------------------------------------------------
// dkm_pkg
// Shared types and constants of the debounced key matrix macro emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dkm_pkg;

	localparam int MAX_OUT = 4;
	localparam int IDX_W   = $clog2(MAX_OUT);
	localparam int CODE_W  = 8;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

	localparam logic [1:0] CTL_ROW_REFRESH = 2'd0;
	localparam logic [1:0] CTL_ROW_MODE_UP = 2'd1;
	localparam logic [1:0] CTL_ROW_MODE_DN = 2'd2;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_MODE    = 2'd2,
		EV_REFRESH = 2'd3
	} event_code_t;

	typedef enum logic [1:0] {
		JOB_MACRO,
		JOB_REFRESH,
		JOB_MODE_UP,
		JOB_MODE_DN
	} job_op_t;

	typedef struct packed {
		job_op_t                          op;
		logic                             level;
		logic [MAX_OUT-1:0][CODE_W-1:0]   codes;
	} job_t;

	typedef struct packed {
		logic              raw;
		logic              stable;
		logic [TIME_W-1:0] stamp;
	} key_state_t;

	typedef enum logic {
		F_IDLE,
		F_EVAL
	} front_state_t;

endpackage

`default_nettype wire

@@ rtl/dkm_ifs.sv @@
// ----------------------------------------------------------------------------
// dkm channel interfaces
// Sample/table-write input, event output and debounce configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dkm_sample_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  row;
	logic [2:0]  column;
	logic [1:0]  slot;
	logic [7:0]  code;
	logic        level;
	logic [31:0] now_ms;
	logic        link_up;

	modport source (output valid, kind, row, column, slot, code, level, now_ms, link_up,
		input ready);
	modport sink (input valid, kind, row, column, slot, code, level, now_ms, link_up,
		output ready);
endinterface

interface dkm_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [7:0] keycode;
	logic [1:0] display_mode;
	logic       refresh_on;
	logic       last;

	modport source (output valid, event_res, keycode, display_mode, refresh_on, last,
		input ready);
	modport sink (input valid, event_res, keycode, display_mode, refresh_on, last,
		output ready);
endinterface

interface dkm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] debounce_ms;

	modport source (output valid, debounce_ms, input ready);
	modport sink (input valid, debounce_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/debounced_key_matrix_macro_emitter.sv @@
// ----------------------------------------------------------------------------
// debounced_key_matrix_macro_emitter
// Per-key debouncer with macro emission and control keys.
// A sample's first event passes the stage-1 registers, job queue and event
// output register. The front takes no new beat until a sample's memory
// read and debounce update are done; the back emits one event per cycle
// while the sink is ready, up to 4 each. Reset sets the refresh flag, clears
// control, mode and per-key valid bits; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_key_matrix_macro_emitter #(
	parameter int ROWS          = 3,
	parameter int COLS          = 5,
	parameter int CODES_PER_KEY = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dkm_sample_if.sink  samples,
	dkm_event_if.source events,
	dkm_cfg_if.sink     cfg
);

	logic [dkm_pkg::DEB_W-1:0] debounce_q;

	logic          push_valid;
	logic          push_ready;
	dkm_pkg::job_t push_job;
	logic          pop_valid;
	logic          pop_ready;
	dkm_pkg::job_t pop_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= dkm_pkg::DEBOUNCE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			debounce_q <= cfg.debounce_ms;
		end
	end

	dkm_front #(
		.ROWS          (ROWS),
		.COLS          (COLS),
		.CODES_PER_KEY (CODES_PER_KEY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.debounce_ms (debounce_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.job         (push_job)
	);

	dkm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	dkm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.events    (events)
	);

endmodule

`default_nettype wire

@@ rtl/dkm_front.sv @@
// ----------------------------------------------------------------------------
// dkm_front
// Accepts samples and table writes, holds the per-key debounce state and the
// macro table, and queues one job for each stable key change that emits.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_front #(
	parameter int ROWS          = 3,
	parameter int COLS          = 5,
	parameter int CODES_PER_KEY = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	dkm_sample_if.sink                     samples,
	input  wire logic [dkm_pkg::DEB_W-1:0] debounce_ms,
	output logic                           push_valid,
	input  wire logic                      push_ready,
	output dkm_pkg::job_t                  job
);

	localparam int KEYS  = ROWS * COLS;
	localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

	dkm_pkg::front_state_t state_q, state_d;

	// storage
	dkm_pkg::key_state_t ks_mem [KEYS];
	logic [dkm_pkg::CODE_W-1:0] mac_mem [KEYS][CODES_PER_KEY];
	logic ks_vld_q  [KEYS];
	logic mac_vld_q [KEYS];

	// stage 1
	dkm_pkg::key_state_t ks_rd_s1;
	logic [dkm_pkg::CODE_W-1:0] mac_rd_s1 [CODES_PER_KEY];
	logic [KEY_W-1:0]           key_s1;
	logic                       level_s1;
	logic [dkm_pkg::TIME_W-1:0] now_s1;
	logic [1:0]                 row_s1;
	logic                       ctl_s1;
	logic                       ks_vld_s1;
	logic                       mac_vld_s1;

	logic             accept;
	logic             in_range;
	logic             slot_ok;
	logic             tbl_wr;
	logic             smp_go;
	logic [KEY_W-1:0] key_idx;
	logic             ks_wr;

	dkm_pkg::key_state_t ks_cur;
	dkm_pkg::key_state_t ks_new;
	logic [dkm_pkg::TIME_W-1:0] elapsed;
	logic                       fire;
	logic                       has_job;
	logic [dkm_pkg::MAX_OUT-1:0][dkm_pkg::CODE_W-1:0] mac_codes;

	assign samples.ready = (state_q == dkm_pkg::F_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign in_range      = (int'(samples.row) < ROWS) && (int'(samples.column) < COLS);
	assign slot_ok       = int'(samples.slot) < CODES_PER_KEY;
	assign key_idx       = KEY_W'(int'(samples.row) * COLS + int'(samples.column));
	assign tbl_wr        = accept && samples.kind && in_range && slot_ok;
	assign smp_go        = accept && !samples.kind && in_range && samples.link_up;

	// macro table: one row per key, per-slot writes; a key's first write clears its other slots
	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			for (int s = 0; s < CODES_PER_KEY; s++) begin
				if (s == int'(samples.slot)) begin
					mac_mem[key_idx][s] <= samples.code;
				end else if (!mac_vld_q[key_idx]) begin
					mac_mem[key_idx][s] <= '0;
				end
			end
		end
		if (smp_go) begin
			mac_rd_s1 <= mac_mem[key_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ks_wr) begin
			ks_mem[key_s1] <= ks_new;
		end
		if (smp_go) begin
			ks_rd_s1 <= ks_mem[key_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEYS; k++) begin
				ks_vld_q[k]  <= 1'b0;
				mac_vld_q[k] <= 1'b0;
			end
		end else begin
			if (tbl_wr) begin
				mac_vld_q[key_idx] <= 1'b1;
			end
			if (ks_wr) begin
				ks_vld_q[key_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_go) begin
			key_s1     <= key_idx;
			level_s1   <= samples.level;
			now_s1     <= samples.now_ms;
			row_s1     <= samples.row;
			ctl_s1     <= int'(samples.column) == COLS - 1;
			ks_vld_s1  <= ks_vld_q[key_idx];
			mac_vld_s1 <= mac_vld_q[key_idx];
		end
	end

	for (genvar gi = 0; gi < dkm_pkg::MAX_OUT; gi++) begin : g_codes
		if (gi < CODES_PER_KEY) begin : g_used
			assign mac_codes[gi] = mac_vld_s1 ? mac_rd_s1[gi] : '0;
		end else begin : g_unused
			assign mac_codes[gi] = '0;
		end
	end

	// debounce evaluation
	always_comb begin
		ks_cur        = ks_vld_s1 ? ks_rd_s1 : '0;
		ks_new.raw    = level_s1;
		ks_new.stamp  = (level_s1 != ks_cur.raw) ? now_s1 : ks_cur.stamp;
		elapsed       = now_s1 - ks_new.stamp;
		fire          = (level_s1 != ks_cur.stable) &&
			(elapsed >= {{(dkm_pkg::TIME_W - dkm_pkg::DEB_W){1'b0}}, debounce_ms});
		ks_new.stable = fire ? level_s1 : ks_cur.stable;

		job.level = level_s1;
		job.codes = mac_codes;
		job.op    = dkm_pkg::JOB_MACRO;
		has_job   = 1'b0;
		if (!ctl_s1) begin
			has_job = fire && (mac_codes[0] != '0);
		end else begin
			unique case (row_s1)
				dkm_pkg::CTL_ROW_REFRESH: begin
					job.op  = dkm_pkg::JOB_REFRESH;
					has_job = fire && level_s1;
				end
				dkm_pkg::CTL_ROW_MODE_UP: begin
					job.op  = dkm_pkg::JOB_MODE_UP;
					has_job = fire && level_s1;
				end
				dkm_pkg::CTL_ROW_MODE_DN: begin
					job.op  = dkm_pkg::JOB_MODE_DN;
					has_job = fire && level_s1;
				end
				default: begin
					has_job = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dkm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ks_wr      = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			dkm_pkg::F_IDLE: begin
				if (smp_go) begin
					state_d = dkm_pkg::F_EVAL;
				end
			end
			dkm_pkg::F_EVAL: begin
				push_valid = has_job;
				if (!has_job || push_ready) begin
					ks_wr   = 1'b1;
					state_d = dkm_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = dkm_pkg::F_IDLE;
			end
		endcase
	end

	a_tbl_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.kind) |=> (state_q == dkm_pkg::F_IDLE))
		else $error("table write left idle");

	a_eval_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == dkm_pkg::F_EVAL) |-> $past(smp_go))
		else $error("evaluation without sample");

endmodule

`default_nettype wire

@@ rtl/dkm_fifo.sv @@
// ----------------------------------------------------------------------------
// dkm_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire dkm_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output dkm_pkg::job_t      pop_job
);

	dkm_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count overflow");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ rtl/dkm_back.sv @@
// ----------------------------------------------------------------------------
// dkm_back
// Expands queued jobs into events, one beat per cycle while the event sink
// is ready, and owns the display mode and refresh flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dkm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire dkm_pkg::job_t job,
	dkm_event_if.source        events
);

	logic [dkm_pkg::IDX_W-1:0] idx_q;
	logic [dkm_pkg::IDX_W-1:0] idx_nx;
	logic [1:0]                mode_q;
	logic                      refresh_q;

	logic                        out_vld_q;
	dkm_pkg::event_code_t        ev_q;
	logic [dkm_pkg::CODE_W-1:0]  kc_q;
	logic [1:0]                  mode_out_q;
	logic                        ref_out_q;
	logic                        last_q;

	logic                        ld;
	dkm_pkg::event_code_t        ev_d;
	logic [dkm_pkg::CODE_W-1:0]  kc_d;
	logic [1:0]                  mode_d;
	logic                        refresh_d;
	logic                        last_d;

	assign ld        = job_valid && (!out_vld_q || events.ready);
	assign idx_nx    = dkm_pkg::IDX_W'(idx_q + dkm_pkg::IDX_W'(1));
	assign job_ready = ld && last_d;

	assign events.valid        = out_vld_q;
	assign events.event_res    = ev_q;
	assign events.keycode      = kc_q;
	assign events.display_mode = mode_out_q;
	assign events.refresh_on   = ref_out_q;
	assign events.last         = last_q;

	always_comb begin
		ev_d      = dkm_pkg::EV_PRESS;
		kc_d      = '0;
		mode_d    = mode_q;
		refresh_d = refresh_q;
		last_d    = 1'b1;
		unique case (job.op)
			dkm_pkg::JOB_MACRO: begin
				ev_d   = job.level ? dkm_pkg::EV_PRESS : dkm_pkg::EV_RELEASE;
				kc_d   = job.codes[idx_q];
				last_d = (idx_q == dkm_pkg::IDX_W'(dkm_pkg::MAX_OUT - 1)) ||
					(job.codes[idx_nx] == '0);
			end
			dkm_pkg::JOB_REFRESH: begin
				ev_d      = dkm_pkg::EV_REFRESH;
				refresh_d = ~refresh_q;
			end
			dkm_pkg::JOB_MODE_UP: begin
				ev_d   = dkm_pkg::EV_MODE;
				mode_d = mode_q + 2'd1;
			end
			dkm_pkg::JOB_MODE_DN: begin
				ev_d   = dkm_pkg::EV_MODE;
				mode_d = mode_q - 2'd1;
			end
			default: begin
				last_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= '0;
			mode_q    <= 2'd0;
			refresh_q <= 1'b1;
		end else begin
			if (ld) begin
				out_vld_q <= 1'b1;
				mode_q    <= mode_d;
				refresh_q <= refresh_d;
				idx_q     <= last_d ? '0 : idx_nx;
			end else if (events.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ev_q       <= ev_d;
			kc_q       <= kc_d;
			mode_out_q <= mode_d;
			ref_out_q  <= refresh_d;
			last_q     <= last_d;
		end
	end

	a_mode_on_job: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mode_q) |->
		$past(ld && (job.op == dkm_pkg::JOB_MODE_UP || job.op == dkm_pkg::JOB_MODE_DN)))
		else $error("mode changed without mode job");

	a_ctl_single: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && job.op != dkm_pkg::JOB_MACRO) |-> job_ready)
		else $error("control job took more than one beat");

endmodule

`default_nettype wire

@@ bench/dkm_event_checker.sv @@
// ----------------------------------------------------------------------------
// dkm_event_checker
// Watches the sample, event and configuration channels of the debounced key
// matrix macro emitter. Keeps its own debounce, macro table, mode and refresh
// state, predicts the events of every accepted sample beat, and compares each
// accepted event beat with the oldest prediction. Reports failures and the
// number of events still outstanding.
// ----------------------------------------------------------------------------

module dkm_event_checker #(
	parameter int ROWS          = 3,
	parameter int COLS          = 5,
	parameter int CODES_PER_KEY = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dkm_sample_if     samples,
	dkm_event_if      events,
	dkm_cfg_if        cfg,
	output int        fail_count,
	output int        pending
);

	localparam int KEYS = ROWS * COLS;

	typedef struct packed {
		dkm_pkg::event_code_t       kind_e;
		logic [dkm_pkg::CODE_W-1:0] keycode;
		logic [1:0]                 mode;
		logic                       refresh;
		logic                       last;
	} key_event_t;

	logic                       raw_lvl    [KEYS];
	logic                       stable_lvl [KEYS];
	logic [dkm_pkg::TIME_W-1:0] change_ms  [KEYS];
	logic [dkm_pkg::CODE_W-1:0] macro_codes[KEYS*CODES_PER_KEY];
	logic [1:0]                 mode_q;
	logic                       refresh_q;
	logic [dkm_pkg::DEB_W-1:0]  debounce_q;
	key_event_t                 expected_events[$];

	function automatic key_event_t make_event(input dkm_pkg::event_code_t k,
		input logic [dkm_pkg::CODE_W-1:0] c);
		key_event_t e;
		e.kind_e  = k;
		e.keycode = c;
		e.mode    = mode_q;
		e.refresh = refresh_q;
		e.last    = 1'b0;
		return e;
	endfunction

	task automatic predict_key_events();
		int                         key;
		int                         first;
		int                         s;
		logic [dkm_pkg::CODE_W-1:0] c;
		logic [dkm_pkg::TIME_W-1:0] elapsed;
		first = expected_events.size();
		if (samples.row >= ROWS || samples.column >= COLS)
			return;
		key = samples.row * COLS + samples.column;
		if (samples.kind) begin
			if (samples.slot < CODES_PER_KEY)
				macro_codes[key*CODES_PER_KEY + samples.slot] = samples.code;
			return;
		end
		if (!samples.link_up)
			return;
		if (samples.level != raw_lvl[key]) begin
			raw_lvl[key]   = samples.level;
			change_ms[key] = samples.now_ms;
		end
		if (samples.level == stable_lvl[key])
			return;
		elapsed = samples.now_ms - change_ms[key];
		if (elapsed < {{(dkm_pkg::TIME_W-dkm_pkg::DEB_W){1'b0}}, debounce_q})
			return;
		stable_lvl[key] = samples.level;
		if (samples.column != COLS - 1) begin
			for (s = 0; s < CODES_PER_KEY; s++) begin
				if (expected_events.size() - first >= dkm_pkg::MAX_OUT)
					break;
				c = macro_codes[key*CODES_PER_KEY + s];
				if (c == '0)
					break;
				expected_events.push_back(make_event(
					samples.level ? dkm_pkg::EV_PRESS : dkm_pkg::EV_RELEASE, c));
			end
		end else if (samples.level) begin
			case (samples.row)
				dkm_pkg::CTL_ROW_REFRESH: begin
					refresh_q = !refresh_q;
					expected_events.push_back(make_event(dkm_pkg::EV_REFRESH, '0));
				end
				dkm_pkg::CTL_ROW_MODE_UP: begin
					mode_q = (mode_q == 2'd3) ? 2'd0 : mode_q + 2'd1;
					expected_events.push_back(make_event(dkm_pkg::EV_MODE, '0));
				end
				dkm_pkg::CTL_ROW_MODE_DN: begin
					mode_q = (mode_q == 2'd0) ? 2'd3 : mode_q - 2'd1;
					expected_events.push_back(make_event(dkm_pkg::EV_MODE, '0));
				end
				default: ;
			endcase
		end
		if (expected_events.size() > first)
			expected_events[expected_events.size()-1].last = 1'b1;
	endtask

	task automatic compare_event();
		key_event_t got;
		key_event_t exp_ev;
		got.kind_e  = dkm_pkg::event_code_t'(events.event_res);
		got.keycode = events.keycode;
		got.mode    = events.display_mode;
		got.refresh = events.refresh_on;
		got.last    = events.last;
		if (expected_events.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected event beat: ev=%0d code=%02h mode=%0d refresh=%0b last=%0b",
				$time, got.kind_e, got.keycode, got.mode, got.refresh, got.last);
			return;
		end
		exp_ev = expected_events.pop_front();
		if (got.kind_e !== exp_ev.kind_e || got.keycode !== exp_ev.keycode ||
			got.mode !== exp_ev.mode || got.refresh !== exp_ev.refresh ||
			got.last !== exp_ev.last) begin
			fail_count++;
			$display("%0t: event mismatch: expected ev=%0d code=%02h mode=%0d refresh=%0b last=%0b",
				$time, exp_ev.kind_e, exp_ev.keycode, exp_ev.mode, exp_ev.refresh, exp_ev.last);
			$display("%0t:                 actual ev=%0d code=%02h mode=%0d refresh=%0b last=%0b",
				$time, got.kind_e, got.keycode, got.mode, got.refresh, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEYS; k++) begin
				raw_lvl[k]    = 1'b0;
				stable_lvl[k] = 1'b0;
				change_ms[k]  = '0;
			end
			for (int m = 0; m < KEYS*CODES_PER_KEY; m++)
				macro_codes[m] = '0;
			mode_q     = 2'd0;
			refresh_q  = 1'b1;
			debounce_q = dkm_pkg::DEBOUNCE_RESET;
			expected_events.delete();
			pending = 0;
		end else begin
			if (events.valid && events.ready)
				compare_event();
			if (cfg.valid && cfg.ready)
				debounce_q = cfg.debounce_ms;
			if (samples.valid && samples.ready)
				predict_key_events();
			pending = expected_events.size();
		end
	end

endmodule

@@ bench/debounced_key_matrix_macro_emitter_tb.sv @@
// ----------------------------------------------------------------------------
// debounced_key_matrix_macro_emitter_tb
// Drives key samples and macro table writes into the emitter: a directed
// pass over the edge cases, then random keystrokes with contact bounce,
// table updates and noise, under several debounce settings and idle/stall
// mixes, including a long event back-pressure stretch. The checker module
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------

module debounced_key_matrix_macro_emitter_tb;

	localparam int   ROWS          = 3;
	localparam int   COLS          = 5;
	localparam int   CODES_PER_KEY = 4;
	localparam int   IDLE_LIMIT    = 4000;
	localparam int   HOLD_CYCLES   = 200;
	localparam int   SETTLE_CYCLES = 12;
	localparam logic KIND_SAMPLE   = 1'b0;
	localparam logic KIND_TABLE    = 1'b1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dkm_sample_if samples();
	dkm_event_if  events();
	dkm_cfg_if    cfg();

	int fail_count;
	int pending;

	debounced_key_matrix_macro_emitter #(
		.ROWS(ROWS), .COLS(COLS), .CODES_PER_KEY(CODES_PER_KEY)
	) dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .events(events), .cfg(cfg)
	);

	dkm_event_checker #(
		.ROWS(ROWS), .COLS(COLS), .CODES_PER_KEY(CODES_PER_KEY)
	) event_chk (
		.clk(clk), .arst_n(arst_n), .samples(samples), .events(events), .cfg(cfg),
		.fail_count(fail_count), .pending(pending)
	);

	always #6 clk = ~clk;

	// event sink: random stalls plus requested long hold-offs
	int stall_pct;
	int hold_reqs;
	int holds_done;
	int hold_left;

	always @(negedge clk) begin
		if (hold_reqs != holds_done) begin
			holds_done = holds_done + 1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			events.ready = 1'b0;
			hold_left--;
		end else begin
			events.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: cycles without any beat on any channel
	int quiet;

	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (events.valid && events.ready) ||
			(cfg.valid && cfg.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("debounced_key_matrix_macro_emitter_tb failed");
			$finish;
		end
	end

	int          src_idle_pct;
	int          counted;
	logic [31:0] now_ms_q;
	logic [15:0] deb_q;
	logic        key_dn[ROWS*COLS];

	task automatic send_beat(input logic kind, input logic [1:0] row, input logic [2:0] column,
		input logic [1:0] slot, input logic [7:0] code, input logic level,
		input logic [31:0] stamp, input logic link);
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid = 1'b0;
			@(negedge clk);
		end
		samples.kind    = kind;
		samples.row     = row;
		samples.column  = column;
		samples.slot    = slot;
		samples.code    = code;
		samples.level   = level;
		samples.now_ms  = stamp;
		samples.link_up = link;
		samples.valid   = 1'b1;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		@(negedge clk);
		samples.valid = 1'b0;
		if (row < ROWS && column < COLS && (kind || link))
			counted++;
	endtask

	task automatic write_table(input logic [1:0] row, input logic [2:0] column,
		input logic [1:0] slot, input logic [7:0] code);
		send_beat(KIND_TABLE, row, column, slot, code, 1'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic key_sample(input logic [1:0] row, input logic [2:0] column, input logic level,
		input logic [31:0] stamp);
		send_beat(KIND_SAMPLE, row, column, 2'($urandom), 8'($urandom), level, stamp, 1'b1);
	endtask

	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_debounce(input logic [15:0] value);
		drain_results();
		cfg.debounce_ms = value;
		cfg.valid       = 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
		deb_q     = value;
	endtask

	// one press or release, sometimes with bounce, sometimes sampled too early
	task automatic key_stroke(input logic [1:0] row, input logic [2:0] column);
		int          key;
		logic        level;
		logic [31:0] hold;
		key   = row * COLS + column;
		level = ~key_dn[key];
		now_ms_q += $urandom_range(1, 50);
		key_sample(row, column, level, now_ms_q);
		if ($urandom_range(4) == 0) begin
			now_ms_q += $urandom_range(0, 3);
			key_sample(row, column, ~level, now_ms_q);
			now_ms_q += $urandom_range(0, 3);
			key_sample(row, column, level, now_ms_q);
		end
		hold = 32'(deb_q);
		if ($urandom_range(5) == 0 && hold > 0)
			hold = hold - 1;
		else
			hold += $urandom_range(0, 2);
		now_ms_q += hold;
		key_sample(row, column, level, now_ms_q);
		key_dn[key] = level;
	endtask

	task automatic random_item();
		int         pick;
		logic [1:0] row;
		logic [2:0] column;
		pick   = $urandom_range(99);
		row    = 2'($urandom_range(ROWS-1));
		column = ($urandom_range(4) == 0) ? 3'(COLS-1) : 3'($urandom_range(COLS-1));
		if (pick < 15) begin
			write_table(row, column, 2'($urandom),
				($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		end else if (pick < 75) begin
			key_stroke(row, column);
		end else if (pick < 88) begin
			now_ms_q += $urandom_range(0, 2*deb_q + 2);
			key_sample(row, column, 1'($urandom), now_ms_q);
		end else begin
			send_beat(1'($urandom), 2'($urandom), 3'($urandom), 2'($urandom), 8'($urandom),
				1'($urandom), ($urandom_range(1) == 0) ? now_ms_q : $urandom, 1'($urandom));
		end
	endtask

	task automatic run_phase(input int n);
		int target;
		target = counted + n;
		while (counted < target)
			random_item();
	endtask

	initial begin
		samples.valid   = 1'b0;
		samples.kind    = KIND_SAMPLE;
		samples.row     = '0;
		samples.column  = '0;
		samples.slot    = '0;
		samples.code    = '0;
		samples.level   = 1'b0;
		samples.now_ms  = '0;
		samples.link_up = 1'b0;
		events.ready    = 1'b0;
		cfg.valid       = 1'b0;
		cfg.debounce_ms = '0;
		src_idle_pct    = 0;
		stall_pct       = 0;
		hold_reqs       = 0;
		holds_done      = 0;
		hold_left       = 0;
		counted         = 0;
		deb_q           = dkm_pkg::DEBOUNCE_RESET;
		for (int k = 0; k < ROWS*COLS; k++)
			key_dn[k] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_debounce(16'd5);
		// full macro with extreme codes, a write outside the matrix, one-code macro
		write_table(2'd0, 3'd0, 2'd0, 8'hFF);
		write_table(2'd0, 3'd0, 2'd1, 8'h01);
		write_table(2'd0, 3'd0, 2'd2, 8'h80);
		write_table(2'd0, 3'd0, 2'd3, 8'h7F);
		send_beat(KIND_TABLE, 2'd3, 3'd7, 2'd0, 8'h55, 1'b1, 32'hFFFF_FFFF, 1'b0);
		write_table(2'd0, 3'd1, 2'd0, 8'h12);
		key_sample(2'd0, 3'd0, 1'b1, 32'd100);
		key_sample(2'd0, 3'd0, 1'b1, 32'd105);
		send_beat(KIND_SAMPLE, 2'd0, 3'd0, 2'd3, 8'hFF, 1'b0, 32'd200, 1'b0);
		key_sample(2'd0, 3'd0, 1'b0, 32'd200);
		key_sample(2'd0, 3'd0, 1'b0, 32'd205);
		// control column: refresh, release is silent, mode down wraps, mode up wraps
		key_sample(2'd0, 3'd4, 1'b1, 32'd300);
		key_sample(2'd0, 3'd4, 1'b1, 32'd305);
		key_sample(2'd0, 3'd4, 1'b0, 32'd310);
		key_sample(2'd0, 3'd4, 1'b0, 32'd315);
		key_sample(2'd2, 3'd4, 1'b1, 32'd320);
		key_sample(2'd2, 3'd4, 1'b1, 32'd325);
		key_sample(2'd1, 3'd4, 1'b1, 32'd330);
		key_sample(2'd1, 3'd4, 1'b1, 32'd335);
		// empty macro, then a hold measured across the timestamp wrap
		key_sample(2'd1, 3'd0, 1'b1, 32'd340);
		key_sample(2'd1, 3'd0, 1'b1, 32'd345);
		key_sample(2'd0, 3'd1, 1'b1, 32'hFFFF_FFFE);
		key_sample(2'd0, 3'd1, 1'b1, 32'h0000_0003);
		now_ms_q = 32'd10;

		write_debounce(16'd0);
		run_phase(45);

		write_debounce(16'hFFFF);
		src_idle_pct = 73;
		run_phase(40);

		write_debounce(16'($urandom_range(1, 200)));
		src_idle_pct = 0;
		stall_pct    = 73;
		run_phase(25);
		drain_results();
		run_phase(15);

		write_debounce(dkm_pkg::DEBOUNCE_RESET);
		src_idle_pct = 22;
		stall_pct    = 22;
		hold_reqs    = hold_reqs + 1;
		run_phase(55);

		src_idle_pct = 0;
		stall_pct    = 0;
		drain_results();
		if (fail_count == 0 && pending == 0)
			$display("debounced_key_matrix_macro_emitter_tb passed");
		else
			$display("debounced_key_matrix_macro_emitter_tb failed");
		$finish;
	end

endmodule
